FILE: hw/rtl/pressure_temperature_compensation_top_defines.svh
// assertion macros for the compensation top
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PTC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PTC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PTC_ASSERT(label, clk, rst, prop, msg)
`define PTC_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/ptc_pkg.sv
// shared types, constants and helpers for the compensation pipeline
package ptc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_T1 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_T2_T3 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_P1_P2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_P3_P4 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_P5_P6 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_P7_P8 = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_P9 = 3'd6;
  localparam int unsigned DivSteps = 32;
  localparam logic [31:0] TfineOffset = 32'd64000;
  localparam logic [31:0] RawFull = 32'd1048576;
  localparam logic [31:0] PScale = 32'd3125;
  localparam logic [31:0] P1Bias = 32'd32768;
  localparam logic [31:0] RoundHalf = 32'd128;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0] pressure_pa;
    logic divide_by_zero;
  } out_item_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [31:0] t2_t3;
    logic [31:0] p1_p2;
    logic [31:0] p3_p4;
    logic [31:0] p5_p6;
    logic [31:0] p7_p8;
    logic [15:0] p9;
  } cal_t;

  // per-item payload while the divider works
  typedef struct packed {
    logic [31:0] tcenti;
    logic [31:0] tfine;
    logic [31:0] num;
    logic [31:0] den;
    logic        big;
    logic        dz;
  } div_ctx_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction
endpackage

FILE: hw/rtl/ptc_front.sv
// temperature compensation and pressure divisor/numerator, pipelined
module ptc_front
  import ptc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_vld,
  input  in_item_t  in_data,
  input  cal_t      cal,
  output logic      out_vld,
  output div_ctx_t  out_ctx
);
  logic [31:0] t2, t3, p1, p2, p3, p4, p5, p6;
  assign t2 = sx16(cal.t2_t3[15:0]);
  assign t3 = sx16(cal.t2_t3[31:16]);
  assign p1 = {16'd0, cal.p1_p2[15:0]};
  assign p2 = sx16(cal.p1_p2[31:16]);
  assign p3 = sx16(cal.p3_p4[15:0]);
  assign p4 = sx16(cal.p3_p4[31:16]);
  assign p5 = sx16(cal.p5_p6[15:0]);
  assign p6 = sx16(cal.p5_p6[31:16]);

  logic [7:0] v;
  // s1
  logic [31:0] s1_ta, s1_dd, s1_up;
  // s2
  logic [31:0] s2_ta, s2_tb, s2_up;
  // s3
  logic [31:0] s3_tfine, s3_up;
  // s4
  logic [31:0] s4_tfine, s4_tc5, s4_a, s4_q, s4_up;
  // s5
  logic [31:0] s5_tfine, s5_tc, s5_qq, s5_a5, s5_p2a, s5_up;
  // s6
  logic [31:0] s6_tfine, s6_tc, s6_b6, s6_p3q, s6_p2a, s6_up, s6_b5;
  // s7
  logic [31:0] s7_tfine, s7_tc, s7_b, s7_a, s7_up;
  // s8
  logic [31:0] s8_tfine, s8_tc, s8_b, s8_den, s8_up;

  logic [31:0] ut, up, d0, s7_asum;
  assign ut = {12'd0, in_data.raw_temperature};
  assign up = {12'd0, in_data.raw_pressure};
  assign d0 = (ut >> 4) - {16'd0, cal.t1};
  assign s7_asum = asr(asr(s6_p3q, 3) + asr(s6_p2a, 1), 18);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ta <= ((ut >> 3) - {15'd0, cal.t1, 1'b0}) * t2;
      s1_dd <= d0 * d0;
      s1_up <= up;

      s2_ta <= asr(s1_ta, 11);
      s2_tb <= asr(s1_dd, 12) * t3;
      s2_up <= s1_up;

      s3_tfine <= s2_ta + asr(s2_tb, 14);
      s3_up <= s2_up;

      s4_tfine <= s3_tfine;
      s4_tc5 <= s3_tfine * 32'd5 + RoundHalf;
      s4_a <= asr(s3_tfine, 1) - TfineOffset;
      s4_q <= asr(asr(s3_tfine, 1) - TfineOffset, 2);
      s4_up <= s3_up;

      s5_tfine <= s4_tfine;
      s5_tc <= asr(s4_tc5, 8);
      s5_qq <= s4_q * s4_q;
      s5_a5 <= s4_a * p5;
      s5_p2a <= p2 * s4_a;
      s5_up <= s4_up;

      s6_tfine <= s5_tfine;
      s6_tc <= s5_tc;
      s6_b6 <= asr(s5_qq, 11) * p6;
      s6_p3q <= p3 * asr(s5_qq, 13);
      s6_p2a <= s5_p2a;
      s6_b5 <= s5_a5 << 1;
      s6_up <= s5_up;

      s7_tfine <= s6_tfine;
      s7_tc <= s6_tc;
      s7_b <= asr(s6_b6 + s6_b5, 2) + (p4 << 16);
      s7_a <= P1Bias + s7_asum;
      s7_up <= s6_up;

      s8_tfine <= s7_tfine;
      s8_tc <= s7_tc;
      s8_b <= s7_b;
      s8_den <= asr(s7_a * p1, 15);
      s8_up <= s7_up;
    end
  end

  logic [31:0] num;
  assign num = ((RawFull - s8_up) - asr(s8_b, 12)) * PScale;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx.tcenti <= s8_tc;
      out_ctx.tfine <= s8_tfine;
      out_ctx.big <= num[31];
      out_ctx.num <= num[31] ? num : (num << 1);
      out_ctx.den <= s8_den;
      out_ctx.dz <= (s8_den == 32'd0);
    end
  end
endmodule

FILE: hw/rtl/ptc_div.sv
// unsigned 32/32 restoring divider, one quotient bit per stage
module ptc_div
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_vld,
  input  div_ctx_t    in_ctx,
  output logic        out_vld,
  output div_ctx_t    out_ctx,
  output logic [31:0] out_quot
);
  logic [DivSteps-1:0]  vld;
  div_ctx_t             ctx [DivSteps];
  logic [31:0]          rem [DivSteps];
  logic [31:0]          quo [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic        v_in;
    div_ctx_t    c_in;
    logic [31:0] r_in;
    logic [31:0] q_in;
    logic [32:0] trial;
    logic [32:0] diff;

    if (i == 0) begin : g_first
      assign v_in = in_vld;
      assign c_in = in_ctx;
      assign r_in = '0;
      assign q_in = in_ctx.num;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign c_in = ctx[i-1];
      assign r_in = rem[i-1];
      assign q_in = quo[i-1];
    end

    assign trial = {r_in, q_in[31]};
    assign diff = trial - {1'b0, c_in.den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx[i] <= c_in;
        if (!diff[32]) begin
          rem[i] <= diff[31:0];
          quo[i] <= {q_in[30:0], 1'b1};
        end else begin
          rem[i] <= trial[31:0];
          quo[i] <= {q_in[30:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld[DivSteps-1];
  assign out_ctx = ctx[DivSteps-1];
  assign out_quot = ctx[DivSteps-1].big ? (quo[DivSteps-1] << 1) : quo[DivSteps-1];
endmodule

FILE: hw/rtl/ptc_back.sv
// final pressure correction after the divide
module ptc_back
  import ptc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_vld,
  input  div_ctx_t  in_ctx,
  input  logic [31:0] in_p,
  input  cal_t      cal,
  output logic      out_vld,
  output out_item_t out_data
);
  logic [31:0] p7, p8, p9;
  assign p7 = sx16(cal.p7_p8[15:0]);
  assign p8 = sx16(cal.p7_p8[31:16]);
  assign p9 = sx16(cal.p9);

  logic [1:0] v;
  logic [31:0] b1_p, b1_qq, b1_b, b1_tc, b1_tf;
  logic [31:0] b2_p, b2_a, b2_b, b2_tc, b2_tf;
  logic b1_dz, b2_dz;
  logic [31:0] q;
  assign q = in_p >> 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      v <= {v[0], in_vld};
      out_vld <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p <= in_p;
      b1_qq <= q * q;
      b1_b <= (in_p >> 2) * p8;
      b1_tc <= in_ctx.tcenti;
      b1_tf <= in_ctx.tfine;
      b1_dz <= in_ctx.dz;

      b2_p <= b1_p;
      b2_a <= p9 * (b1_qq >> 13);
      b2_b <= asr(b1_b, 13);
      b2_tc <= b1_tc;
      b2_tf <= b1_tf;
      b2_dz <= b1_dz;

      out_data.temperature_centi <= b2_tc;
      out_data.fine_temperature <= b2_tf;
      out_data.divide_by_zero <= b2_dz;
      out_data.pressure_pa <= b2_dz ? 32'd0 :
          b2_p + asr(asr(b2_a, 12) + b2_b + p7, 4);
    end
  end
endmodule

FILE: hw/rtl/pressure_temperature_compensation_top.sv
// Compensation of raw temperature/pressure readings into centi-degrees and pascals.
// One reading pair is taken every cycle unless back pressure stalls it; the path is 8 front
// stages, one numerator stage, 32 divider stages and 3 correction stages, with the
// bit-per-stage divider the longest part. Back pressure freezes the whole pipeline.
`include "pressure_temperature_compensation_top_defines.svh"
module pressure_temperature_compensation_top
  import ptc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);
  cal_t cal;
  logic en;
  logic f_vld, d_vld;
  div_ctx_t f_ctx, d_ctx;
  logic [31:0] d_q;

  // stall all stages while the output holds an untaken result
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_T1:    cal.t1 <= cfg_data[15:0];
        REG_T2_T3: cal.t2_t3 <= cfg_data;
        REG_P1_P2: cal.p1_p2 <= cfg_data;
        REG_P3_P4: cal.p3_p4 <= cfg_data;
        REG_P5_P6: cal.p5_p6 <= cfg_data;
        REG_P7_P8: cal.p7_p8 <= cfg_data;
        REG_P9:    cal.p9 <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ptc_front u_front (
    .clk, .rst, .en,
    .in_vld(in_valid && in_ready), .in_data, .cal,
    .out_vld(f_vld), .out_ctx(f_ctx)
  );

  ptc_div u_div (
    .clk, .rst, .en,
    .in_vld(f_vld), .in_ctx(f_ctx),
    .out_vld(d_vld), .out_ctx(d_ctx), .out_quot(d_q)
  );

  ptc_back u_back (
    .clk, .rst, .en,
    .in_vld(d_vld), .in_ctx(d_ctx), .in_p(d_q), .cal,
    .out_vld(out_valid), .out_data
  );

  `PTC_ASSERT(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed under stall")
  `PTC_ASSERT(a_ready_tracks, clk, rst, in_ready == (!out_valid || out_ready), "ready not tied to output slot")
  `PTC_ASSERT(a_dz_zero, clk, rst, out_valid && out_data.divide_by_zero |-> out_data.pressure_pa == 32'd0, "zero divisor gave pressure")
  `PTC_ASSERT_RST(a_reset_empty, clk, rst |=> !out_valid, "result after reset")
endmodule

FILE: tb/sv/tb_pressure_temperature_compensation_top.sv
// testbench for the barometric compensation pipeline: predictor, directed table, random readings
`timescale 1ns / 100ps
module tb_pressure_temperature_compensation_top;
  import ptc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_T1;
  logic [31:0] cfg_data = '0;

  pressure_temperature_compensation_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  localparam int PipeLatency = 44;
  localparam int CycleLimit = 400000;

  cal_t cal_shadow = '0;
  out_item_t expected_q[$];
  int errors = 0;
  int readings_sent = 0;
  int results_seen = 0;
  int zero_div_seen = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;

  function automatic logic [31:0] sra32(logic [31:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] sign16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // fixed-point compensation, all intermediates wrap at 32 bits
  function automatic out_item_t compensate(in_item_t r);
    out_item_t o;
    logic [31:0] ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, q, tfine, p;
    ut = {12'd0, r.raw_temperature};
    up = {12'd0, r.raw_pressure};
    t1 = {16'd0, cal_shadow.t1};
    t2 = sign16(cal_shadow.t2_t3[15:0]);
    t3 = sign16(cal_shadow.t2_t3[31:16]);
    p1 = {16'd0, cal_shadow.p1_p2[15:0]};
    p2 = sign16(cal_shadow.p1_p2[31:16]);
    p3 = sign16(cal_shadow.p3_p4[15:0]);
    p4 = sign16(cal_shadow.p3_p4[31:16]);
    p5 = sign16(cal_shadow.p5_p6[15:0]);
    p6 = sign16(cal_shadow.p5_p6[31:16]);
    p7 = sign16(cal_shadow.p7_p8[15:0]);
    p8 = sign16(cal_shadow.p7_p8[31:16]);
    p9 = sign16(cal_shadow.p9);
    a = sra32(((ut >> 3) - (t1 << 1)) * t2, 11);
    d = (ut >> 4) - t1;
    b = sra32(sra32(d * d, 12) * t3, 14);
    tfine = a + b;
    o.fine_temperature = tfine;
    o.temperature_centi = sra32(tfine * 32'd5 + 32'd128, 8);
    a = sra32(tfine, 1) - 32'd64000;
    q = sra32(a, 2);
    b = sra32(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra32(b, 2) + (p4 << 16);
    a = sra32(sra32(p3 * sra32(q * q, 13), 3) + sra32(p2 * a, 1), 18);
    a = sra32((32'd32768 + a) * p1, 15);
    if (a == 0) begin
      o.pressure_pa = '0;
      o.divide_by_zero = 1'b1;
    end else begin
      p = ((32'd1048576 - up) - sra32(b, 12)) * 32'd3125;
      if (p < 32'h80000000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      q = p >> 3;
      a = sra32(p9 * ((q * q) >> 13), 12);
      b = sra32((p >> 2) * p8, 13);
      o.pressure_pa = p + sra32(a + b + p7, 4);
      o.divide_by_zero = 1'b0;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s at result %0d: got %h want %h", what, results_seen, got, want);
  endtask

  // result side: random stalls, compare each transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t w;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("unexpected result %0d", results_seen);
      end else begin
        w = expected_q.pop_front();
        if (out_data.temperature_centi !== w.temperature_centi)
          report_mismatch("temperature_centi", out_data.temperature_centi, w.temperature_centi);
        if (out_data.fine_temperature !== w.fine_temperature)
          report_mismatch("fine_temperature", out_data.fine_temperature, w.fine_temperature);
        if (out_data.pressure_pa !== w.pressure_pa)
          report_mismatch("pressure_pa", out_data.pressure_pa, w.pressure_pa);
        if (out_data.divide_by_zero !== w.divide_by_zero)
          report_mismatch("divide_by_zero", 32'(out_data.divide_by_zero),
                          32'(w.divide_by_zero));
        if (w.divide_by_zero) zero_div_seen++;
      end
      results_seen++;
    end
  end

  initial begin : ready_side
    int n;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin
    if (cycle_count == 0) @(posedge clk);
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // called at a falling edge; leaves valid high, caller lowers it when done
  task automatic send_reading(in_item_t r, bit check_fixed, out_item_t fixed);
    out_item_t pred;
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(negedge clk);
    end
    pred = compensate(r);
    if (check_fixed && pred !== fixed) begin
      errors++;
      $display("table row %0d disagrees with prediction", readings_sent);
    end
    expected_q.push_back(check_fixed ? fixed : pred);
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    readings_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (PipeLatency + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_T1: cal_shadow.t1 = v[15:0];
      REG_T2_T3: cal_shadow.t2_t3 = v;
      REG_P1_P2: cal_shadow.p1_p2 = v;
      REG_P3_P4: cal_shadow.p3_p4 = v;
      REG_P5_P6: cal_shadow.p5_p6 = v;
      REG_P7_P8: cal_shadow.p7_p8 = v;
      REG_P9: cal_shadow.p9 = v[15:0];
      default: ;
    endcase
  endtask

  // typical sensor calibration, shifted a little
  task automatic load_typical;
    write_reg(REG_T1, 32'd27504 + $urandom_range(0, 200));
    write_reg(REG_T2_T3, {16'hFC18, 16'd26435});
    write_reg(REG_P1_P2, {16'hD5D0, 16'd36477 + 16'($urandom_range(0, 300))});
    write_reg(REG_P3_P4, {16'd2855, 16'd3024});
    write_reg(REG_P5_P6, {16'hFFF9, 16'd140});
    write_reg(REG_P7_P8, {16'hD0A8, 16'd15500});
    write_reg(REG_P9, 32'd6000);
  endtask

  task automatic load_random;
    write_reg(REG_T1, $urandom());
    write_reg(REG_T2_T3, $urandom());
    write_reg(REG_P1_P2, $urandom());
    write_reg(REG_P3_P4, $urandom());
    write_reg(REG_P5_P6, $urandom());
    write_reg(REG_P7_P8, $urandom());
    write_reg(REG_P9, $urandom());
  endtask

  typedef struct {
    logic [19:0] ut;
    logic [19:0] up;
    bit fixed;
    logic [31:0] tc;
    logic [31:0] tf;
    logic [31:0] pa;
    logic dz;
  } row_t;

  row_t reset_rows[4] = '{
    // all coefficients zero: tfine 0, divisor 0
    '{20'd0, 20'd0, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1},
    '{20'hFFFFF, 20'hFFFFF, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1},
    '{20'hAAAAA, 20'h55555, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1},
    '{20'h55555, 20'hAAAAA, 1'b1, 32'd0, 32'd0, 32'd0, 1'b1}
  };
  row_t cal_rows[10] = '{
    '{20'd519888, 20'd415148, 1'b0, 0, 0, 0, 0},
    '{20'd0, 20'd0, 1'b0, 0, 0, 0, 0},
    '{20'hFFFFF, 20'hFFFFF, 1'b0, 0, 0, 0, 0},
    '{20'd0, 20'hFFFFF, 1'b0, 0, 0, 0, 0},
    '{20'hFFFFF, 20'd0, 1'b0, 0, 0, 0, 0},
    '{20'd440064, 20'd1, 1'b0, 0, 0, 0, 0},
    '{20'd600000, 20'd300000, 1'b0, 0, 0, 0, 0},
    '{20'd300000, 20'd600000, 1'b0, 0, 0, 0, 0},
    '{20'h80000, 20'h80000, 1'b0, 0, 0, 0, 0},
    '{20'h7FFFF, 20'h7FFFF, 1'b0, 0, 0, 0, 0}
  };

  task automatic walk(row_t rows[]);
    in_item_t r;
    out_item_t f;
    foreach (rows[i]) begin
      r.raw_temperature = rows[i].ut;
      r.raw_pressure = rows[i].up;
      f.temperature_centi = rows[i].tc;
      f.fine_temperature = rows[i].tf;
      f.pressure_pa = rows[i].pa;
      f.divide_by_zero = rows[i].dz;
      send_reading(r, rows[i].fixed, f);
    end
  endtask

  task automatic random_readings(int count, bit realistic);
    in_item_t r;
    out_item_t f;
    f = '0;
    repeat (count) begin
      if (realistic) begin
        r.raw_temperature = 20'($urandom_range(400000, 620000));
        r.raw_pressure = 20'($urandom_range(250000, 500000));
      end else begin
        r.raw_temperature = 20'($urandom());
        r.raw_pressure = 20'($urandom());
      end
      send_reading(r, 1'b0, f);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    walk(reset_rows);
    drain();
    load_typical();
    walk(cal_rows);
    drain();
    // extremes of every coefficient
    write_reg(REG_T1, 32'hFFFF);
    write_reg(REG_T2_T3, 32'h80007FFF);
    write_reg(REG_P1_P2, 32'h7FFFFFFF);
    write_reg(REG_P3_P4, 32'h80007FFF);
    write_reg(REG_P5_P6, 32'h7FFF8000);
    write_reg(REG_P7_P8, 32'h80007FFF);
    write_reg(REG_P9, 32'h8000);
    walk(cal_rows);
    drain();
    write_reg(REG_T1, 32'd0);
    write_reg(REG_T2_T3, 32'hFFFFFFFF);
    write_reg(REG_P1_P2, 32'hFFFF0001);
    write_reg(REG_P9, 32'h7FFF);
    walk(cal_rows);
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 2) load_random(); else load_typical();
      random_readings(130, ph % 3 != 2);
      // full hold-off until the pipe is empty
      drain();
    end
    quiet = 1'b1;
    load_typical();
    random_readings(250, 1'b1);
    drain();
    $display("sent %0d readings over several calibrations, %0d results, %0d zero-divisor",
             readings_sent, results_seen, zero_div_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_front.sv
hw/rtl/ptc_div.sv
hw/rtl/ptc_back.sv
hw/rtl/pressure_temperature_compensation_top.sv
tb/sv/tb_pressure_temperature_compensation_top.sv
